// ===== rtl/amon_pkg.sv =====
package amon_pkg;

  localparam int CHANNELS    = 16;
  localparam int CH_AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHAN_BITS   = 4;
  localparam int SAMPLE_BITS = 32;

  localparam int S_FIELD_BITS = CHAN_BITS + 4 * SAMPLE_BITS + 2;
  localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
  localparam int M_FIELD_BITS = CHAN_BITS + 2 + 2 * SAMPLE_BITS;
  localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

  typedef logic signed [SAMPLE_BITS-1:0] value_t;
  typedef logic [CHAN_BITS-1:0]          chan_t;
  typedef logic [1:0]                    level_t;

  localparam level_t LVL_NORMAL   = 2'd0;
  localparam level_t LVL_LOW      = 2'd1;
  localparam level_t LVL_DANGER   = 2'd2;
  localparam level_t LVL_CRITICAL = 2'd3;

  localparam logic ACT_CHECK = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic   action;
    chan_t  channel;
    value_t sample;
    logic   sample_valid;
    logic   monitor_enabled;
    value_t critical_limit;
    value_t danger_limit;
    value_t low_limit;
  } item_t;

  typedef struct packed {
    logic   wr_en;
    level_t wr_level;
    logic   evt;
    value_t crossed;
    logic   failure;
  } grade_t;

endpackage

// ===== rtl/amon_level_ram.sv =====
module amon_level_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 2
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/amon_grade.sv =====
module amon_grade (
  input  amon_pkg::item_t  item_i,
  input  logic             seen_i,
  input  amon_pkg::level_t prev_level_i,
  input  amon_pkg::value_t failure_marker_i,
  output amon_pkg::grade_t grade_o
);

  amon_pkg::level_t lvl;
  amon_pkg::level_t prev_eff;
  amon_pkg::value_t crossed;
  logic             failure;
  logic             in_range;
  logic             quiet_mark;

  assign in_range = int'(item_i.channel) < amon_pkg::CHANNELS;
  assign prev_eff = seen_i ? prev_level_i : amon_pkg::LVL_NORMAL;

  always_comb begin
    lvl        = amon_pkg::LVL_NORMAL;
    crossed    = '0;
    failure    = 1'b0;
    quiet_mark = 1'b0;
    if (!item_i.sample_valid) begin
      if (!seen_i) begin
        quiet_mark = 1'b1;
      end else begin
        lvl     = amon_pkg::LVL_CRITICAL;
        crossed = failure_marker_i;
        failure = 1'b1;
      end
    end else if (item_i.sample >= item_i.critical_limit) begin
      lvl     = amon_pkg::LVL_CRITICAL;
      crossed = item_i.critical_limit;
    end else if (item_i.sample >= item_i.danger_limit) begin
      lvl     = amon_pkg::LVL_DANGER;
      crossed = item_i.danger_limit;
    end else if (item_i.sample <= item_i.low_limit) begin
      lvl     = amon_pkg::LVL_LOW;
      crossed = item_i.low_limit;
    end
  end

  always_comb begin
    grade_o          = '0;
    grade_o.wr_level = lvl;
    grade_o.crossed  = crossed;
    grade_o.failure  = failure;
    if (item_i.action == amon_pkg::ACT_CHECK && item_i.monitor_enabled && in_range) begin
      if (quiet_mark) begin
        grade_o.wr_en    = 1'b1;
        grade_o.wr_level = amon_pkg::LVL_NORMAL;
      end else if (lvl != prev_eff) begin
        grade_o.wr_en = 1'b1;
        grade_o.evt   = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/multichannel_alarm_level_monitor.sv =====
// Multichannel alarm level monitor.
// Samples arrive on the s_axis channel, one word per sample; tuser set means
// the word is a clear action that forgets the level history of all channels.
// Level change events leave on the m_axis channel, tuser marking events that
// were caused by invalid sensor data. The cfg channel writes the failure
// marker reported in such events; it is always ready.
// A sample is taken every cycle unless an event waits in the grading stage
// for a busy output register. The level table is read at the accepting edge;
// grading, the table write and the output register load for m_axis take
// effect as the grading stage passes the word on. Samples on one channel may
// follow each other directly; the new level is forwarded around the table.
// Reset marks every channel as unseen and sets the failure marker to zero;
// no clearing pass is needed, as a seen flag per channel is kept in flops.
// When the receiver stalls, the event stays in the output register and one
// more sample is held in the grading stage; samples that cause no event keep
// passing while the grading stage is free.
module multichannel_alarm_level_monitor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // channel, sample, sample_valid, monitor_enabled, critical_limit,
  // danger_limit, low_limit, zero fill
  input  logic [amon_pkg::S_TDATA_BITS-1:0]   s_axis_tdata,
  // action
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // event_channel, event_level, event_value, crossed_limit, zero fill
  output logic [amon_pkg::M_TDATA_BITS-1:0]   m_axis_tdata,
  // sensor_failure
  output logic                                m_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [amon_pkg::SAMPLE_BITS-1:0]    cfg_data_i
);

  localparam int SB = amon_pkg::SAMPLE_BITS;
  localparam int CB = amon_pkg::CHAN_BITS;

  amon_pkg::item_t  in_item;
  amon_pkg::item_t  s1_item_q;
  logic             s1_valid_q;
  logic             s1_go;
  logic             accept;
  amon_pkg::grade_t grade;
  amon_pkg::value_t marker_q;
  logic [amon_pkg::CHANNELS-1:0] seen_q;
  logic             fwd_hit_q;
  amon_pkg::level_t fwd_level_q;
  amon_pkg::level_t ram_rdata;
  amon_pkg::level_t prev_level;
  logic             seen;
  logic             wr_en;
  logic [amon_pkg::CH_AW-1:0] s1_idx;
  logic [amon_pkg::CH_AW-1:0] in_idx;
  logic             out_valid_q;
  logic [amon_pkg::M_TDATA_BITS-1:0] out_data_q;
  logic             out_user_q;
  logic             out_free;

  assign in_item.action          = s_axis_tuser;
  assign in_item.channel         = s_axis_tdata[CB-1:0];
  assign in_item.sample          = s_axis_tdata[CB+SB-1:CB];
  assign in_item.sample_valid    = s_axis_tdata[CB+SB];
  assign in_item.monitor_enabled = s_axis_tdata[CB+SB+1];
  assign in_item.critical_limit  = s_axis_tdata[CB+2*SB+1:CB+SB+2];
  assign in_item.danger_limit    = s_axis_tdata[CB+3*SB+1:CB+2*SB+2];
  assign in_item.low_limit       = s_axis_tdata[CB+4*SB+1:CB+3*SB+2];

  assign in_idx = in_item.channel[amon_pkg::CH_AW-1:0];
  assign s1_idx = s1_item_q.channel[amon_pkg::CH_AW-1:0];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_go         = s1_valid_q && (!grade.evt || out_free);
  assign s_axis_tready = !s1_valid_q || s1_go;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign wr_en         = s1_go && grade.wr_en;
  assign cfg_ready_o   = 1'b1;

  amon_level_ram #(
    .DEPTH(amon_pkg::CHANNELS),
    .AW   (amon_pkg::CH_AW),
    .DW   (2)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(s1_idx),
    .wdata_i(grade.wr_level),
    .re_i   (accept),
    .raddr_i(in_idx),
    .rdata_o(ram_rdata)
  );

  assign prev_level = fwd_hit_q ? fwd_level_q : ram_rdata;
  assign seen       = seen_q[s1_idx];

  amon_grade u_grade (
    .item_i          (s1_item_q),
    .seen_i          (seen),
    .prev_level_i    (prev_level),
    .failure_marker_i(marker_q),
    .grade_o         (grade)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= '0;
    end else if (cfg_valid_i) begin
      marker_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      fwd_hit_q  <= wr_en && (s1_idx == in_idx);
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q   <= in_item;
      fwd_level_q <= grade.wr_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (s1_go && s1_item_q.action == amon_pkg::ACT_CLEAR) begin
      seen_q <= '0;
    end else if (wr_en) begin
      seen_q[s1_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && grade.evt) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && grade.evt) begin
      out_data_q <= {{(amon_pkg::M_TDATA_BITS - amon_pkg::M_FIELD_BITS){1'b0}},
                     grade.crossed, s1_item_q.sample, grade.wr_level, s1_item_q.channel};
      out_user_q <= grade.failure;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  a_clear_forgets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_item_q.action == amon_pkg::ACT_CLEAR |=> seen_q == '0)
    else $error("clear action left a channel marked as seen");

  a_failure_is_critical: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[CB+1:CB] == amon_pkg::LVL_CRITICAL)
    else $error("sensor failure event with a level other than critical");

  a_normal_no_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[CB+1:CB] == amon_pkg::LVL_NORMAL
      |-> !m_axis_tuser && m_axis_tdata[CB+2*SB+1:CB+SB+2] == '0)
    else $error("normal event carries a limit or a failure flag");

  a_forward_only_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_valid_q)
    else $error("forwarding flag set with no word in the grading stage");
`endif

endmodule
